>>> hw/rtl/ido_pkg.sv
// Shared types, constants and helpers for the inhalation dose detector.
// No dependencies; every other RTL file refers to this package by scoped names.
`default_nettype none

package ido_pkg;

  // Sizing and scaling
  localparam int AVG_SAMPLES    = 5;
  localparam int PRESSURE_SHIFT = 6;

  localparam int RAW_W    = 24;
  localparam int PA_W     = 18;
  localparam int SUM_W    = 21;
  localparam int CNT_W    = 3;
  localparam int TILT_W   = 15;
  localparam int ACCEL_W  = 16;
  localparam int DOSE_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;

  localparam logic [PA_W-1:0] PA_MAX = '1;

  // Reciprocal for the baseline average: exact floor for any SUM_W-bit sum
  localparam int AVG_LOG   = $clog2(AVG_SAMPLES);
  localparam int AVG_SHIFT = SUM_W + AVG_LOG;
  localparam int RECIP_W   = AVG_SHIFT + 1;
  localparam logic [RECIP_W-1:0] AVG_RECIP =
    RECIP_W'(((64'd1 << AVG_SHIFT) + 64'(AVG_SAMPLES) - 64'd1) / 64'(AVG_SAMPLES));

  // Reset values of the configuration registers
  localparam logic [PA_W-1:0]   THRESHOLD_RST = PA_W'(1000);
  localparam logic [TILT_W-1:0] TILT_RST      = TILT_W'(300);
  localparam logic [DOSE_W-1:0] CAPACITY_RST  = DOSE_W'(255);

  // Item kinds
  localparam logic OP_PRESSURE = 1'b0;
  localparam logic OP_ACCEL    = 1'b1;

  // Posture codes
  localparam logic [1:0] POSTURE_OK   = 2'd0;
  localparam logic [1:0] POSTURE_HIGH = 2'd1;
  localparam logic [1:0] POSTURE_LOW  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TILT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 2'd2;

  typedef struct packed {
    logic                      op;
    logic [RAW_W-1:0]          raw_pressure;
    logic signed [ACCEL_W-1:0] accel_x;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        posture;
    logic              dose_taken;
    logic [PA_W-1:0]   pressure_change;
    logic [PA_W-1:0]   baseline_pa;
    logic              baseline_busy;
    logic [DOSE_W-1:0] doses_left;
    logic [DOSE_W-1:0] doses_given;
  } out_item_t;

  // Scale a raw word to pascals and saturate
  function automatic logic [PA_W-1:0] to_pascals(input logic [RAW_W-1:0] raw);
    logic [RAW_W-1:0] sh;
    sh = raw >> PRESSURE_SHIFT;
    if (sh > RAW_W'(PA_MAX)) begin
      return PA_MAX;
    end
    return sh[PA_W-1:0];
  endfunction

  // Divide the sample sum by AVG_SAMPLES through the reciprocal
  function automatic logic [PA_W-1:0] sum_average(input logic [SUM_W-1:0] sum);
    logic [SUM_W+RECIP_W-1:0] prod;
    logic [SUM_W+RECIP_W-1:0] quo;
    prod = (SUM_W+RECIP_W)'(sum) * (SUM_W+RECIP_W)'(AVG_RECIP);
    quo  = prod >> AVG_SHIFT;
    return quo[PA_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ido_out_buf.sv
// Two-entry result buffer between the compute stage and the output channel.
// Depends on ido_pkg for the result beat type.
`default_nettype none

module ido_out_buf (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire ido_pkg::out_item_t push_data_i,
  output logic                   room_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output ido_pkg::out_item_t     out_data_o
);

  ido_pkg::out_item_t entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != 2'd0);
  assign out_data_o  = entry_q[rd_ptr_q];
  assign room_o      = (count_q != 2'd2);

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop;
    count_d  = count_q + 2'(push_i) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold result beats
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q != 2'd2))
    else $error("result pushed into a full buffer");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("buffer occupancy out of range");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((count_q == 2'd0) || (count_q == 2'd2)) |-> (wr_ptr_q == rd_ptr_q))
    else $error("pointers disagree with occupancy");

endmodule

`default_nettype wire

>>> hw/rtl/ido_core.sv
// Input register, configuration registers and the per-item dose detection logic.
// Depends on ido_pkg for types, constants and the scaling and averaging helpers.
`default_nettype none

module ido_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire ido_pkg::in_item_t                   in_data_i,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [ido_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [ido_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire logic                                room_i,
  output logic                                     push_o,
  output ido_pkg::out_item_t                       push_data_o
);

  // Input stage
  ido_pkg::in_item_t item_q;
  logic              item_valid_q;
  logic              fire;
  logic              cfg_fire;

  // Configuration
  logic [ido_pkg::PA_W-1:0]   threshold_q;
  logic [ido_pkg::TILT_W-1:0] tilt_q;

  // Detector state
  logic                        mode_q, mode_d;
  logic [ido_pkg::SUM_W-1:0]   sum_q, sum_d;
  logic [ido_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [ido_pkg::PA_W-1:0]    baseline_q, baseline_d;
  logic [ido_pkg::PA_W-1:0]    change_q, change_d;
  logic [1:0]                  posture_q, posture_d;
  logic [ido_pkg::DOSE_W-1:0]  remaining_q, remaining_d;
  logic [ido_pkg::DOSE_W-1:0]  given_q, given_d;
  logic                        taken;

  // Datapath temporaries
  logic [ido_pkg::PA_W-1:0]    pa;
  logic [ido_pkg::SUM_W-1:0]   sum_add;
  logic [ido_pkg::CNT_W:0]     cnt_inc;
  logic [ido_pkg::PA_W-1:0]    diff;
  logic signed [ido_pkg::ACCEL_W-1:0] lim_pos;
  logic signed [ido_pkg::ACCEL_W-1:0] lim_neg;

  assign fire        = item_valid_q && room_i;
  assign in_ready_o  = !item_valid_q || room_i;
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  // Hold the accepted beat until the result buffer takes its result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
  end

  // Scaled pressure, running sum, distance from baseline, tilt bounds
  always_comb begin
    pa      = ido_pkg::to_pascals(item_q.raw_pressure);
    sum_add = sum_q + ido_pkg::SUM_W'(pa);
    cnt_inc = {1'b0, cnt_q} + (ido_pkg::CNT_W+1)'(1);
    diff    = (baseline_q >= pa) ? (baseline_q - pa) : (pa - baseline_q);
    lim_pos = signed'({1'b0, tilt_q});
    lim_neg = -lim_pos;
  end

  // Next state for one item
  always_comb begin
    mode_d      = mode_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    baseline_d  = baseline_q;
    change_d    = change_q;
    posture_d   = posture_q;
    remaining_d = remaining_q;
    given_d     = given_q;
    taken       = 1'b0;

    if (fire && (remaining_q != '0)) begin
      if (item_q.op == ido_pkg::OP_PRESSURE) begin
        if (mode_q) begin
          if (cnt_inc >= (ido_pkg::CNT_W+1)'(ido_pkg::AVG_SAMPLES)) begin
            baseline_d = ido_pkg::sum_average(sum_add);
            sum_d      = '0;
            cnt_d      = '0;
            mode_d     = 1'b0;
          end else begin
            sum_d = sum_add;
            cnt_d = cnt_inc[ido_pkg::CNT_W-1:0];
          end
        end else begin
          change_d = diff;
          if (diff > threshold_q) begin
            taken       = 1'b1;
            remaining_d = remaining_q - ido_pkg::DOSE_W'(1);
            given_d     = given_q + ido_pkg::DOSE_W'(1);
            mode_d      = 1'b1;
            sum_d       = '0;
            cnt_d       = '0;
          end
        end
      end else if (!mode_q) begin
        if (item_q.accel_x > lim_pos) begin
          posture_d = ido_pkg::POSTURE_HIGH;
        end else if (item_q.accel_x < lim_neg) begin
          posture_d = ido_pkg::POSTURE_LOW;
        end else begin
          posture_d = ido_pkg::POSTURE_OK;
        end
      end
    end

    // A capacity write reloads the remaining count
    if (cfg_fire && (cfg_index_i == ido_pkg::REG_CAPACITY)) begin
      remaining_d = cfg_data_i[ido_pkg::DOSE_W-1:0];
    end
  end

  // Result beat reflects the state after this item
  assign push_o = fire;
  always_comb begin
    push_data_o.posture         = posture_d;
    push_data_o.dose_taken      = taken;
    push_data_o.pressure_change = change_d;
    push_data_o.baseline_pa     = baseline_d;
    push_data_o.baseline_busy   = mode_d;
    push_data_o.doses_left      = remaining_d;
    push_data_o.doses_given     = given_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b1;
      sum_q       <= '0;
      cnt_q       <= '0;
      baseline_q  <= '0;
      change_q    <= '0;
      posture_q   <= ido_pkg::POSTURE_OK;
      remaining_q <= ido_pkg::CAPACITY_RST;
      given_q     <= '0;
    end else begin
      mode_q      <= mode_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      baseline_q  <= baseline_d;
      change_q    <= change_d;
      posture_q   <= posture_d;
      remaining_q <= remaining_d;
      given_q     <= given_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ido_pkg::THRESHOLD_RST;
      tilt_q      <= ido_pkg::TILT_RST;
    end else if (cfg_fire) begin
      unique case (cfg_index_i)
        ido_pkg::REG_THRESHOLD: threshold_q <= cfg_data_i[ido_pkg::PA_W-1:0];
        ido_pkg::REG_TILT:      tilt_q      <= cfg_data_i[ido_pkg::TILT_W-1:0];
        default: ;
      endcase
    end
  end

  a_count_below_avg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, cnt_q} < (ido_pkg::CNT_W+1)'(ido_pkg::AVG_SAMPLES)))
    else $error("sample count reached the average length");

  a_empty_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (remaining_q == '0) && !cfg_fire) |=>
      ($stable(given_q) && $stable(mode_q) && $stable(baseline_q)))
    else $error("state changed with no doses left");

  a_dose_rebaselines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && taken) |=> (mode_q && (sum_q == '0) && (cnt_q == '0)))
    else $error("dose did not restart baseline averaging");

  a_dose_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && taken) |=> (given_q == $past(given_q) + ido_pkg::DOSE_W'(1)))
    else $error("dose not counted");

endmodule

`default_nettype wire

>>> hw/rtl/inhalation_dose_detector.sv
// Top level of the inhalation dose detector: detection core and result buffer.
// Depends on ido_pkg, ido_core and ido_out_buf.
//
//   channel | direction | handshake            | beat
//   --------+-----------+----------------------+---------------------------------
//   in      | input     | in_valid_i/in_ready_o   | ido_pkg::in_item_t
//   out     | output    | out_valid_o/out_ready_i | ido_pkg::out_item_t
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item per cycle sustained while out_ready_i is high; each result passes through the input
// register, then the one-pass detector logic into the two-entry result buffer.
// Reset loads the register defaults, starts baseline averaging and needs no clearing pass.
// Configuration writes are taken every cycle. When out_ready_i is low the buffer fills,
// then the input register holds and in_ready_o drops.
`default_nettype none

module inhalation_dose_detector (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire ido_pkg::in_item_t               in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output ido_pkg::out_item_t                   out_data_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [ido_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [ido_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  logic               room;
  logic               push;
  ido_pkg::out_item_t push_data;

  // Detection core
  ido_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .room_i      (room),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Result buffer
  ido_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
